// ----- hw/rtl/tfmfh_pkg.sv -----
// ----------------------------------------------------------------------------
// tfmfh_pkg
// Shared types and constants of the triple-field multilane fnv hash unit.
// ----------------------------------------------------------------------------
package tfmfh_pkg;

    localparam int NUM_LANES  = 8;
    localparam int NUM_PARTS  = 3;
    localparam int LANE_IDX_W = 3;

    typedef logic [31:0]           lane_t;
    typedef logic [LANE_IDX_W-1:0] lane_idx_t;

    localparam lane_t FNV_PRIME = 32'd16777619;
    localparam lane_t FNV_BASIS = 32'd2166136261;
    localparam lane_t ADD_PART0 = 32'h9e3779b9;
    localparam lane_t ADD_PART1 = 32'h85ebca6b;
    localparam lane_t ADD_PART2 = 32'hc2b2ae35;
    localparam lane_t FIN_MUL   = 32'h85ebca6b;

    localparam lane_t LANE_SEEDS [NUM_LANES] = '{
        32'h811c9dc5, 32'h84222325, 32'h9e3779b1, 32'hc2b2ae35,
        32'h27d4eb2f, 32'h165667b1, 32'h85ebca6b, 32'h9b05688c
    };

    localparam logic [1:0] PART_COLLECTION  = 2'd0;
    localparam logic [1:0] PART_OBSERVATION = 2'd1;
    localparam logic [1:0] PART_SOLUTION    = 2'd2;
    localparam logic [1:0] PART_NONE        = 2'd3;

    localparam lane_idx_t LANE_LAST = lane_idx_t'(NUM_LANES - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WAIT = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_MIX  = 4'b1000
    } state_t;

    typedef struct packed {
        logic      step;
        logic      fin_mul;
        logic      fin_mix;
        logic      fin_done;
        lane_idx_t lane;
    } cmd_t;

endpackage

// ----- hw/rtl/tfmfh_ctrl.sv -----
// ----------------------------------------------------------------------------
// tfmfh_ctrl
// Controller: input handshake, finalize sequencing over the lanes and the
// result valid flag.
// ----------------------------------------------------------------------------
module tfmfh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             last,
    output logic             out_valid,
    input  logic             out_ready,
    output tfmfh_pkg::cmd_t  cmd
);

    tfmfh_pkg::state_t    state_reg, state_next;
    tfmfh_pkg::lane_idx_t lane_reg, lane_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 accept;
    logic                 last_lane;

    assign in_ready  = (state_reg == tfmfh_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign last_lane = (lane_reg == tfmfh_pkg::LANE_LAST);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        lane_next  = lane_reg;
        case (state_reg)
            tfmfh_pkg::ST_IDLE:
            begin
                if (accept && last)
                begin
                    state_next = tfmfh_pkg::ST_WAIT;
                end
            end
            tfmfh_pkg::ST_WAIT:
            begin
                // result registers must be free before they are overwritten
                if (!out_valid_reg)
                begin
                    state_next = tfmfh_pkg::ST_MUL;
                    lane_next  = '0;
                end
            end
            tfmfh_pkg::ST_MUL:
            begin
                state_next = tfmfh_pkg::ST_MIX;
            end
            tfmfh_pkg::ST_MIX:
            begin
                lane_next = lane_reg + tfmfh_pkg::lane_idx_t'(1);
                if (last_lane)
                begin
                    state_next = tfmfh_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tfmfh_pkg::ST_MUL;
                end
            end
            default:
            begin
                state_next = tfmfh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == tfmfh_pkg::ST_MIX) && last_lane)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        cmd.step     = accept;
        cmd.fin_mul  = (state_reg == tfmfh_pkg::ST_MUL);
        cmd.fin_mix  = (state_reg == tfmfh_pkg::ST_MIX);
        cmd.fin_done = (state_reg == tfmfh_pkg::ST_MIX) && last_lane;
        cmd.lane     = lane_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfmfh_pkg::ST_IDLE;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/tfmfh_datapath.sv -----
// ----------------------------------------------------------------------------
// tfmfh_datapath
// Lane accumulators, per-part codes, shared finalize multiplier and result
// registers.
// ----------------------------------------------------------------------------
module tfmfh_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  tfmfh_pkg::cmd_t cmd,
    input  logic [7:0]      data_byte,
    input  logic [1:0]      part,
    input  logic            byte_valid,
    output logic [63:0]     hash_word_0,
    output logic [63:0]     hash_word_1,
    output logic [63:0]     hash_word_2,
    output logic [63:0]     hash_word_3,
    output logic [31:0]     collection_code,
    output logic [31:0]     observation_code,
    output logic [31:0]     solution_code
);

    // multiply by 16777619 as shifts and adds
    function automatic tfmfh_pkg::lane_t fnv_mul(input tfmfh_pkg::lane_t x);
        fnv_mul = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction

    tfmfh_pkg::lane_t acc_reg      [tfmfh_pkg::NUM_LANES];
    tfmfh_pkg::lane_t acc_next     [tfmfh_pkg::NUM_LANES];
    tfmfh_pkg::lane_t fin_reg      [tfmfh_pkg::NUM_LANES];
    tfmfh_pkg::lane_t code_reg     [tfmfh_pkg::NUM_PARTS];
    tfmfh_pkg::lane_t code_next    [tfmfh_pkg::NUM_PARTS];
    tfmfh_pkg::lane_t code_out_reg [tfmfh_pkg::NUM_PARTS];
    tfmfh_pkg::lane_t mul_reg;
    tfmfh_pkg::lane_t part_add;
    tfmfh_pkg::lane_t byte_ext;
    tfmfh_pkg::lane_t mix_in;
    tfmfh_pkg::lane_t mul_prod;
    logic             byte_en;

    assign byte_en  = cmd.step && byte_valid && (part != tfmfh_pkg::PART_NONE);
    assign byte_ext = {24'd0, data_byte};

    always_comb
    begin
        case (part)
            tfmfh_pkg::PART_COLLECTION:  part_add = tfmfh_pkg::ADD_PART0;
            tfmfh_pkg::PART_OBSERVATION: part_add = tfmfh_pkg::ADD_PART1;
            tfmfh_pkg::PART_SOLUTION:    part_add = tfmfh_pkg::ADD_PART2;
            default:                     part_add = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < tfmfh_pkg::NUM_LANES; i++)
        begin
            acc_next[i] = fnv_mul(acc_reg[i] ^ byte_ext) + part_add;
        end
        for (int j = 0; j < tfmfh_pkg::NUM_PARTS; j++)
        begin
            code_next[j] = fnv_mul(code_reg[j] ^ byte_ext);
        end
    end

    // shared finalize unit, one lane at a time through a multiply and a mix step
    assign mix_in   = acc_reg[cmd.lane] ^ (acc_reg[cmd.lane] >> 16);
    assign mul_prod = mix_in * tfmfh_pkg::FIN_MUL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tfmfh_pkg::NUM_LANES; i++)
            begin
                acc_reg[i] <= tfmfh_pkg::LANE_SEEDS[i];
            end
            for (int j = 0; j < tfmfh_pkg::NUM_PARTS; j++)
            begin
                code_reg[j] <= tfmfh_pkg::FNV_BASIS;
            end
        end
        else if (cmd.fin_done)
        begin
            for (int i = 0; i < tfmfh_pkg::NUM_LANES; i++)
            begin
                acc_reg[i] <= tfmfh_pkg::LANE_SEEDS[i];
            end
            for (int j = 0; j < tfmfh_pkg::NUM_PARTS; j++)
            begin
                code_reg[j] <= tfmfh_pkg::FNV_BASIS;
            end
        end
        else if (byte_en)
        begin
            for (int i = 0; i < tfmfh_pkg::NUM_LANES; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
            for (int j = 0; j < tfmfh_pkg::NUM_PARTS; j++)
            begin
                if (part == 2'(j))
                begin
                    code_reg[j] <= code_next[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_mul)
        begin
            mul_reg <= mul_prod;
        end
        if (cmd.fin_mix)
        begin
            fin_reg[cmd.lane] <= mul_reg ^ (mul_reg >> 13);
        end
        if (cmd.fin_done)
        begin
            for (int j = 0; j < tfmfh_pkg::NUM_PARTS; j++)
            begin
                code_out_reg[j] <= code_reg[j];
            end
        end
    end

    assign hash_word_0      = {fin_reg[0], fin_reg[1]};
    assign hash_word_1      = {fin_reg[2], fin_reg[3]};
    assign hash_word_2      = {fin_reg[4], fin_reg[5]};
    assign hash_word_3      = {fin_reg[6], fin_reg[7]};
    assign collection_code  = code_out_reg[0];
    assign observation_code = code_out_reg[1];
    assign solution_code    = code_out_reg[2];

endmodule

// ----- hw/rtl/triple_field_multilane_fnv_hash_unit.sv -----
// ----------------------------------------------------------------------------
// triple_field_multilane_fnv_hash_unit
// Hashes a stream of tagged bytes into eight fnv lanes and three part codes,
// emitting the finalized 256-bit hash and the codes on each last request.
// ----------------------------------------------------------------------------
// throughput: one byte request per cycle while in_ready is high; a last
// request holds the input through any wait for the previous result to be
// taken and through finalize; the result is valid once the shared finalize
// multiplier has taken each of the 8 lanes through a multiply and a mix step
// reset: lanes return to their seeds, part codes to the fnv basis, no result
// pending; lanes and part codes return to it after each result is formed
module triple_field_multilane_fnv_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  part,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_word_0,
    output logic [63:0] hash_word_1,
    output logic [63:0] hash_word_2,
    output logic [63:0] hash_word_3,
    output logic [31:0] collection_code,
    output logic [31:0] observation_code,
    output logic [31:0] solution_code
);

    tfmfh_pkg::cmd_t cmd;

    tfmfh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tfmfh_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .data_byte        (data_byte),
        .part             (part),
        .byte_valid       (byte_valid),
        .hash_word_0      (hash_word_0),
        .hash_word_1      (hash_word_1),
        .hash_word_2      (hash_word_2),
        .hash_word_3      (hash_word_3),
        .collection_code  (collection_code),
        .observation_code (observation_code),
        .solution_code    (solution_code)
    );

    // finalize never overwrites a result still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_mix |-> !out_valid)
        else $error("finalize while result pending");

    // a last request stops input until finalize is over
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input taken during finalize");

    // a result appears only at the end of finalize
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.fin_done))
        else $error("result without finalize");

    // no byte is folded in while finalizing
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin_mul || cmd.fin_mix) |-> !cmd.step)
        else $error("byte step during finalize");

endmodule
